FILE: sv/dss_pkg.sv
package dss_pkg;

  // Defaults for the top-level parameters.
  localparam int DEF_NUM_SETS    = 2048;
  localparam int DEF_NUM_WAYS    = 16;
  localparam int DEF_SIG_ENTRIES = 4096;
  localparam int DEF_DUEL_PERIOD = 32;
  localparam int DEF_RRPV_WIDTH  = 3;
  localparam int DEF_SEL_WIDTH   = 10;

  // Fixed field widths of the stream payloads.
  localparam int SET_IDX_W  = 11;
  localparam int WAY_IDX_W  = 4;
  localparam int PC_W       = 64;
  localparam int SIG_LSB    = 2;
  localparam int VICTIM_W   = 4;
  localparam int SEL_OUT_W  = 10;
  localparam int IN_DATA_W  = 80;
  localparam int OUT_DATA_W = 16;

  // Bit positions inside in_tdata.
  localparam int SET_LSB = 0;
  localparam int WAY_LSB = SET_LSB + SET_IDX_W;
  localparam int PC_LSB  = WAY_LSB + WAY_IDX_W;
  localparam int HIT_BIT = PC_LSB + PC_W;

  // Outcome counters of the signature table.
  localparam int               CTR_W     = 3;
  localparam logic [CTR_W-1:0] CTR_TOP   = {CTR_W{1'b1}};
  localparam logic [CTR_W-1:0] CTR_START = CTR_W'(3);

  // Request kinds carried in in_tuser.
  localparam logic REQ_VICTIM = 1'b0;
  localparam logic REQ_UPDATE = 1'b1;

  // Sample-set roles, as the set index modulo the dueling period.
  localparam int ROLE_SRRIP_SAMPLE = 0;
  localparam int ROLE_SHIP_SAMPLE  = 1;

endpackage

FILE: sv/dss_ram.sv
module dss_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // A read in the same cycle as a write to the same address returns the old data.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: sv/dss_mod_unit.sv
module dss_mod_unit #(
  parameter int IN_W    = 11,
  parameter int DIVISOR = 2048,
  localparam int OUT_W  = $clog2(DIVISOR)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [IN_W-1:0]  dividend,
  output logic             done,
  output logic [OUT_W-1:0] remainder
);

  if ((DIVISOR & (DIVISOR - 1)) == 0) begin : g_pow2
    localparam int EXT_W = (IN_W > OUT_W) ? IN_W : OUT_W;

    logic [EXT_W-1:0] ext;
    logic [OUT_W-1:0] rem_r;
    logic             done_r;

    assign ext = EXT_W'(dividend);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        done_r <= 1'b0;
      end else if (start) begin
        done_r <= 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (start) begin
        rem_r <= ext[OUT_W-1:0];
      end
    end

    assign done      = done_r;
    assign remainder = rem_r;
  end else begin : g_serial
    // Restoring reduction, one dividend bit per cycle from the top down.
    localparam int CNT_W = $clog2(IN_W);

    logic [CNT_W-1:0] cnt_r;
    logic [OUT_W-1:0] acc_r;
    logic [IN_W-1:0]  sh_r;
    logic             busy_r;
    logic             done_r;
    logic [OUT_W:0]   trial;
    logic [OUT_W:0]   step;

    assign trial = {acc_r, sh_r[IN_W-1]};
    assign step  = (trial >= (OUT_W + 1)'(DIVISOR)) ? trial - (OUT_W + 1)'(DIVISOR) : trial;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        busy_r <= 1'b0;
        done_r <= 1'b0;
        cnt_r  <= '0;
      end else if (start) begin
        busy_r <= 1'b1;
        done_r <= 1'b0;
        cnt_r  <= '0;
      end else if (busy_r) begin
        if (cnt_r == CNT_W'(IN_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r + 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (start) begin
        acc_r <= '0;
        sh_r  <= dividend;
      end else if (busy_r) begin
        acc_r <= step[OUT_W-1:0];
        sh_r  <= sh_r << 1;
      end
    end

    assign done      = done_r;
    assign remainder = acc_r;
  end

endmodule

FILE: sv/dss_max_scan.sv
module dss_max_scan #(
  parameter int NUM_WAYS   = 16,
  parameter int RRPV_WIDTH = 3,
  localparam int WAY_BITS  = $clog2(NUM_WAYS),
  localparam int ROW_W     = NUM_WAYS * RRPV_WIDTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [ROW_W-1:0]      rrpv_row,
  output logic                  done,
  output logic [WAY_BITS-1:0]   victim,
  output logic [RRPV_WIDTH-1:0] max_rrpv
);

  logic [WAY_BITS-1:0]   cnt_r;
  logic [WAY_BITS-1:0]   best_r;
  logic [RRPV_WIDTH-1:0] top_r;
  logic                  busy_r;
  logic                  done_r;
  logic [RRPV_WIDTH-1:0] cur;

  assign cur = rrpv_row[cnt_r * RRPV_WIDTH +: RRPV_WIDTH];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (busy_r) begin
      if (cnt_r == WAY_BITS'(NUM_WAYS - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end else begin
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end

  // Strict compare keeps the lowest way among equal maxima.
  always_ff @(posedge clk) begin
    if (start) begin
      top_r  <= '0;
      best_r <= '0;
    end else if (busy_r && (cur > top_r)) begin
      top_r  <= cur;
      best_r <= cnt_r;
    end
  end

  assign done     = done_r;
  assign victim   = best_r;
  assign max_rrpv = top_r;

endmodule

FILE: sv/dueling_ship_srrip_replacement.sv
// SHiP/SRRIP replacement engine with set dueling. Each transaction on the input stream is either a
// victim request (in_tuser = 0) or an access update (in_tuser = 1), and each gives exactly one
// result transaction. The block handles one request at a time and holds in_tready low while it
// works. For a victim request the largest RRPV of the set is found by one comparator stepping
// over the ways, one way per cycle. Every per-request step is a read-modify-write of one set
// row plus at most two counter-table reads and one counter-table write, on memories with one
// read port and one write port. A size that is not a power of two is reduced by a bit-serial
// modulo unit; for SIG_ENTRIES that reduction overlaps the reductions of NUM_SETS and
// DUEL_PERIOD. After reset the block clears the set-metadata and counter memories, one entry
// per cycle, before it takes its first request. A finished result waits in an output register,
// so the next request can be taken while the previous result is still pending.
module dueling_ship_srrip_replacement
  import dss_pkg::*;
#(
  parameter int NUM_SETS    = DEF_NUM_SETS,
  parameter int NUM_WAYS    = DEF_NUM_WAYS,
  parameter int SIG_ENTRIES = DEF_SIG_ENTRIES,
  parameter int DUEL_PERIOD = DEF_DUEL_PERIOD,
  parameter int RRPV_WIDTH  = DEF_RRPV_WIDTH,
  parameter int SEL_WIDTH   = DEF_SEL_WIDTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // Fields from bit 0: set_index[10:0], way_index[14:11], pc_value[78:15], was_hit[79].
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // Fields from bit 0: req_type[0].
  input  logic                  in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // Fields from bit 0: victim_way[3:0], ship_in_use[4], selector_value[14:5], zero fill[15].
  output logic [OUT_DATA_W-1:0] out_tdata
);

  localparam int SET_BITS  = $clog2(NUM_SETS);
  localparam int WAY_BITS  = $clog2(NUM_WAYS);
  localparam int SIG_BITS  = $clog2(SIG_ENTRIES);
  localparam int DUEL_BITS = $clog2(DUEL_PERIOD);
  localparam int RW        = RRPV_WIDTH;
  localparam int SIG_IN_W  = PC_W - SIG_LSB;

  // Set row layout: RRPVs, then reused flags, then signatures.
  localparam int REU_OFF = NUM_WAYS * RW;
  localparam int SIG_OFF = NUM_WAYS * (RW + 1);
  localparam int ROW_W   = NUM_WAYS * (RW + 1 + SIG_BITS);

  localparam int CLR_DEPTH = (NUM_SETS > SIG_ENTRIES) ? NUM_SETS : SIG_ENTRIES;
  localparam int CLR_W     = $clog2(CLR_DEPTH);

  localparam logic [RW-1:0]        RRPV_TOP  = {RW{1'b1}};
  localparam logic [RW-1:0]        RRPV_LONG = RRPV_TOP - 1'b1;
  localparam logic [SEL_WIDTH-1:0] SEL_TOP   = {SEL_WIDTH{1'b1}};
  localparam logic [SEL_WIDTH-1:0] SEL_START = SEL_TOP >> 1;
  localparam logic [ROW_W-1:0]     ROW_RESET = ROW_W'({NUM_WAYS{RRPV_TOP}});

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_MOD1,
    S_MOD2,
    S_SCAN,
    S_CTR1,
    S_CTR2,
    S_FIN
  } state_t;

  state_t                state_r, state_nxt;
  logic [CLR_W-1:0]      clr_r, clr_nxt;
  logic                  req_r, req_nxt;
  logic [WAY_IDX_W-1:0]  way_r, way_nxt;
  logic                  hit_r, hit_nxt;
  logic                  ship_r, ship_nxt;
  logic                  role0_r, role0_nxt;
  logic                  role1_r, role1_nxt;
  logic [SEL_WIDTH-1:0]  sel_r, sel_nxt;
  logic [WAY_BITS-1:0]   victim_r, victim_nxt;
  logic                  fwd_r, fwd_nxt;
  logic [CTR_W-1:0]      fwd_val_r, fwd_val_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [VICTIM_W-1:0]   out_victim_r, out_victim_nxt;
  logic                  out_ship_r, out_ship_nxt;
  logic [SEL_OUT_W-1:0]  out_sel_r, out_sel_nxt;

  logic                  set_start, set_done;
  logic [SET_BITS-1:0]   set_rem;
  logic                  sig_start, sig_done;
  logic [SIG_BITS-1:0]   sig_rem;
  logic                  duel_start, duel_done;
  logic [DUEL_BITS-1:0]  duel_rem;
  logic                  scan_start, scan_done;
  logic [WAY_BITS-1:0]   scan_victim;
  logic [RW-1:0]         scan_max;

  logic                  row_we, row_re;
  logic [SET_BITS-1:0]   row_waddr, row_raddr;
  logic [ROW_W-1:0]      row_wdata, row_rdata;
  logic                  ctr_we, ctr_re;
  logic [SIG_BITS-1:0]   ctr_waddr, ctr_raddr;
  logic [CTR_W-1:0]      ctr_wdata, ctr_rdata;

  logic                  accept;
  logic                  way_ok;
  logic [WAY_BITS-1:0]   widx;
  logic [SIG_BITS-1:0]   old_sig;
  logic                  old_reused;
  logic                  ctr_inc, ctr_dec, ctr_change;
  logic [CTR_W-1:0]      ctr_mod;
  logic [CTR_W-1:0]      ctr_new_val;
  logic [RW-1:0]         ins_rrpv;
  logic [RW-1:0]         age_add;
  logic [ROW_W-1:0]      row_upd;
  logic [ROW_W-1:0]      row_aged;
  logic                  is_role0, is_role1, ship_now;

  assign accept = in_tvalid && in_tready;

  dss_mod_unit #(.IN_W(SET_IDX_W), .DIVISOR(NUM_SETS)) u_set_mod (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (set_start),
    .dividend  (in_tdata[SET_LSB +: SET_IDX_W]),
    .done      (set_done),
    .remainder (set_rem)
  );

  dss_mod_unit #(.IN_W(SIG_IN_W), .DIVISOR(SIG_ENTRIES)) u_sig_mod (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (sig_start),
    .dividend  (in_tdata[PC_LSB + SIG_LSB +: SIG_IN_W]),
    .done      (sig_done),
    .remainder (sig_rem)
  );

  dss_mod_unit #(.IN_W(SET_BITS), .DIVISOR(DUEL_PERIOD)) u_duel_mod (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (duel_start),
    .dividend  (set_rem),
    .done      (duel_done),
    .remainder (duel_rem)
  );

  dss_max_scan #(.NUM_WAYS(NUM_WAYS), .RRPV_WIDTH(RW)) u_scan (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (scan_start),
    .rrpv_row (row_rdata[REU_OFF-1:0]),
    .done     (scan_done),
    .victim   (scan_victim),
    .max_rrpv (scan_max)
  );

  dss_ram #(.WIDTH(ROW_W), .DEPTH(NUM_SETS)) u_row_ram (
    .clk   (clk),
    .we    (row_we),
    .waddr (row_waddr),
    .wdata (row_wdata),
    .re    (row_re),
    .raddr (row_raddr),
    .rdata (row_rdata)
  );

  dss_ram #(.WIDTH(CTR_W), .DEPTH(SIG_ENTRIES)) u_ctr_ram (
    .clk   (clk),
    .we    (ctr_we),
    .waddr (ctr_waddr),
    .wdata (ctr_wdata),
    .re    (ctr_re),
    .raddr (ctr_raddr),
    .rdata (ctr_rdata)
  );

  // Line fields of the addressed way, taken from the set row that was read.
  assign way_ok     = int'(way_r) < NUM_WAYS;
  assign widx       = WAY_BITS'(way_r);
  assign old_sig    = row_rdata[SIG_OFF + widx * SIG_BITS +: SIG_BITS];
  assign old_reused = row_rdata[REU_OFF + widx];

  // Training of the counter that belongs to the line's old signature.
  assign ctr_inc    = way_ok && ship_r && hit_r && (ctr_rdata != CTR_TOP);
  assign ctr_dec    = way_ok && ship_r && !hit_r && !old_reused && (ctr_rdata != '0);
  assign ctr_change = ctr_inc || ctr_dec;
  assign ctr_mod    = ctr_inc ? ctr_rdata + 1'b1 : ctr_rdata - 1'b1;

  // The new signature's counter may just have been written in the previous cycle.
  assign ctr_new_val = fwd_r ? fwd_val_r : ctr_rdata;

  always_comb begin
    if (!ship_r) begin
      ins_rrpv = RRPV_LONG;
    end else if (ctr_new_val > CTR_START) begin
      ins_rrpv = '0;
    end else if (ctr_new_val == '0) begin
      ins_rrpv = RRPV_TOP;
    end else begin
      ins_rrpv = RRPV_LONG;
    end
  end

  always_comb begin
    row_upd = row_rdata;
    if (hit_r) begin
      row_upd[widx * RW +: RW] = '0;
      if (ship_r) begin
        row_upd[REU_OFF + widx] = 1'b1;
      end
    end else begin
      row_upd[SIG_OFF + widx * SIG_BITS +: SIG_BITS] = sig_rem;
      row_upd[REU_OFF + widx]                        = 1'b0;
      row_upd[widx * RW +: RW]                       = ins_rrpv;
    end
  end

  // Aging adds the distance to the top RRPV to every way at once.
  assign age_add = RRPV_TOP - scan_max;

  always_comb begin
    row_aged = row_rdata;
    for (int w = 0; w < NUM_WAYS; w++) begin
      row_aged[w * RW +: RW] = row_rdata[w * RW +: RW] + age_add;
    end
  end

  assign is_role0 = duel_rem == DUEL_BITS'(ROLE_SRRIP_SAMPLE);
  assign is_role1 = duel_rem == DUEL_BITS'(ROLE_SHIP_SAMPLE);
  assign ship_now = is_role1 || (!is_role0 && (sel_r >= SEL_START));

  always_comb begin
    state_nxt      = state_r;
    clr_nxt        = clr_r;
    req_nxt        = req_r;
    way_nxt        = way_r;
    hit_nxt        = hit_r;
    ship_nxt       = ship_r;
    role0_nxt      = role0_r;
    role1_nxt      = role1_r;
    sel_nxt        = sel_r;
    victim_nxt     = victim_r;
    fwd_nxt        = fwd_r;
    fwd_val_nxt    = fwd_val_r;
    out_victim_nxt = out_victim_r;
    out_ship_nxt   = out_ship_r;
    out_sel_nxt    = out_sel_r;
    out_valid_nxt  = out_valid_r && !out_tready;

    set_start  = 1'b0;
    sig_start  = 1'b0;
    duel_start = 1'b0;
    scan_start = 1'b0;
    row_we     = 1'b0;
    row_waddr  = set_rem;
    row_wdata  = row_upd;
    row_re     = 1'b0;
    row_raddr  = set_rem;
    ctr_we     = 1'b0;
    ctr_waddr  = old_sig;
    ctr_wdata  = ctr_mod;
    ctr_re     = 1'b0;
    ctr_raddr  = old_sig;

    unique case (state_r)
      S_CLEAR: begin
        row_we    = int'(clr_r) < NUM_SETS;
        row_waddr = clr_r[SET_BITS-1:0];
        row_wdata = ROW_RESET;
        ctr_we    = int'(clr_r) < SIG_ENTRIES;
        ctr_waddr = clr_r[SIG_BITS-1:0];
        ctr_wdata = CTR_START;
        clr_nxt   = clr_r + 1'b1;
        if (clr_r == CLR_W'(CLR_DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          req_nxt   = in_tuser;
          way_nxt   = in_tdata[WAY_LSB +: WAY_IDX_W];
          hit_nxt   = in_tdata[HIT_BIT];
          set_start = 1'b1;
          sig_start = 1'b1;
          state_nxt = S_MOD1;
        end
      end
      S_MOD1: begin
        if (set_done) begin
          duel_start = 1'b1;
          row_re     = 1'b1;
          state_nxt  = S_MOD2;
        end
      end
      S_MOD2: begin
        if (duel_done && sig_done) begin
          ship_nxt  = ship_now;
          role0_nxt = is_role0;
          role1_nxt = is_role1;
          if (req_r == REQ_VICTIM) begin
            scan_start = 1'b1;
            state_nxt  = S_SCAN;
          end else begin
            ctr_re    = 1'b1;
            state_nxt = S_CTR1;
          end
        end
      end
      S_SCAN: begin
        if (scan_done) begin
          row_we     = 1'b1;
          row_wdata  = row_aged;
          victim_nxt = scan_victim;
          state_nxt  = S_FIN;
        end
      end
      S_CTR1: begin
        ctr_we      = ctr_change;
        ctr_re      = 1'b1;
        ctr_raddr   = sig_rem;
        fwd_nxt     = ctr_change && (old_sig == sig_rem);
        fwd_val_nxt = ctr_mod;
        state_nxt   = S_CTR2;
      end
      S_CTR2: begin
        row_we     = way_ok;
        victim_nxt = '0;
        if (way_ok && hit_r) begin
          if (role0_r && (sel_r != '0)) begin
            sel_nxt = sel_r - 1'b1;
          end else if (role1_r && (sel_r != SEL_TOP)) begin
            sel_nxt = sel_r + 1'b1;
          end
        end
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt  = 1'b1;
          out_victim_nxt = VICTIM_W'(victim_r);
          out_ship_nxt   = ship_r;
          out_sel_nxt    = SEL_OUT_W'(sel_r);
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      sel_r       <= SEL_START;
      fwd_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      sel_r       <= sel_nxt;
      fwd_r       <= fwd_nxt;
      out_valid_r <= out_valid_nxt;
    end
    req_r        <= req_nxt;
    way_r        <= way_nxt;
    hit_r        <= hit_nxt;
    ship_r       <= ship_nxt;
    role0_r      <= role0_nxt;
    role1_r      <= role1_nxt;
    victim_r     <= victim_nxt;
    fwd_val_r    <= fwd_val_nxt;
    out_victim_r <= out_victim_nxt;
    out_ship_r   <= out_ship_nxt;
    out_sel_r    <= out_sel_nxt;
  end

  assign in_tready  = state_r == S_IDLE;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_sel_r, out_ship_r, out_victim_r};

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import dss_pkg::*;

  localparam int NUM_LINES   = DEF_NUM_SETS * DEF_NUM_WAYS;
  localparam int RRPV_MAX    = (1 << DEF_RRPV_WIDTH) - 1;
  localparam int RRPV_LONG   = RRPV_MAX - 1;
  localparam int SEL_MAX     = (1 << DEF_SEL_WIDTH) - 1;
  localparam int SEL_MID     = SEL_MAX >> 1;
  localparam int SIG_W       = $clog2(DEF_SIG_ENTRIES);
  localparam int CYCLE_LIMIT = 300000;

  typedef struct packed {
    logic [VICTIM_W-1:0]  victim_way;
    logic                 ship_in_use;
    logic [SEL_OUT_W-1:0] selector_value;
  } replacement_reply_t;

  // Mirror of the replacement state; it works out the reply of every accepted
  // request and keeps the replies in arrival order.
  class replacement_mirror;
    logic [DEF_RRPV_WIDTH-1:0] line_rrpv [NUM_LINES];
    logic                      line_reused [NUM_LINES];
    logic [SIG_W-1:0]          line_sig [NUM_LINES];
    logic [CTR_W-1:0]          outcome_ctr [DEF_SIG_ENTRIES];
    logic [DEF_SEL_WIDTH-1:0]  selector;
    replacement_reply_t        awaited_replies [$];
    int                        errors;

    function new();
      foreach (line_rrpv[i]) begin
        line_rrpv[i]   = RRPV_MAX;
        line_reused[i] = 1'b0;
        line_sig[i]    = '0;
      end
      foreach (outcome_ctr[i]) outcome_ctr[i] = CTR_START;
      selector = SEL_MID;
      errors   = 0;
    endfunction

    function void apply_request(logic req, logic [IN_DATA_W-1:0] data);
      int unsigned        set_i, way_i, base, line, role, top, first, new_sig, old_sig;
      logic [PC_W-1:0]    pc;
      logic               hit, ship;
      replacement_reply_t reply;
      set_i = data[SET_LSB +: SET_IDX_W] % DEF_NUM_SETS;
      way_i = data[WAY_LSB +: WAY_IDX_W];
      pc    = data[PC_LSB +: PC_W];
      hit   = data[HIT_BIT];
      base  = set_i * DEF_NUM_WAYS;
      role  = set_i % DEF_DUEL_PERIOD;
      // Followers take their policy from the selector as it stood before this request.
      ship  = (role == ROLE_SHIP_SAMPLE) ||
              (role != ROLE_SRRIP_SAMPLE && selector >= SEL_MID);
      reply.victim_way = '0;
      if (req == REQ_VICTIM) begin
        top   = 0;
        first = 0;
        for (int w = 0; w < DEF_NUM_WAYS; w++) begin
          if (line_rrpv[base + w] > top) begin
            top   = line_rrpv[base + w];
            first = w;
          end
        end
        // Age the whole set at once until the largest value reaches the maximum.
        if (top < RRPV_MAX) begin
          for (int w = 0; w < DEF_NUM_WAYS; w++)
            line_rrpv[base + w] = line_rrpv[base + w] + (RRPV_MAX - top);
        end
        reply.victim_way = first;
      end else if (way_i < DEF_NUM_WAYS) begin
        line = base + way_i;
        if (hit) begin
          line_rrpv[line] = '0;
          if (ship) begin
            line_reused[line] = 1'b1;
            if (outcome_ctr[line_sig[line]] < CTR_TOP)
              outcome_ctr[line_sig[line]] = outcome_ctr[line_sig[line]] + 1;
          end
          if (role == ROLE_SRRIP_SAMPLE) begin
            if (selector > 0) selector = selector - 1;
          end else if (role == ROLE_SHIP_SAMPLE) begin
            if (selector < SEL_MAX) selector = selector + 1;
          end
        end else begin
          new_sig = (pc >> SIG_LSB) % DEF_SIG_ENTRIES;
          old_sig = line_sig[line];
          if (ship && !line_reused[line] && outcome_ctr[old_sig] > 0)
            outcome_ctr[old_sig] = outcome_ctr[old_sig] - 1;
          line_sig[line]    = new_sig;
          line_reused[line] = 1'b0;
          if (!ship)                             line_rrpv[line] = RRPV_LONG;
          else if (outcome_ctr[new_sig] > CTR_START) line_rrpv[line] = '0;
          else if (outcome_ctr[new_sig] == 0)    line_rrpv[line] = RRPV_MAX;
          else                                   line_rrpv[line] = RRPV_LONG;
        end
      end
      reply.ship_in_use    = ship;
      reply.selector_value = selector;
      awaited_replies.push_back(reply);
    endfunction

    function void compare_reply(logic [OUT_DATA_W-1:0] data);
      replacement_reply_t want;
      if (awaited_replies.size() == 0) begin
        $display("%0t: reply with none awaited, expected nothing, got %h", $time, data);
        errors++;
        return;
      end
      want = awaited_replies.pop_front();
      if (data[3:0] !== want.victim_way) begin
        $display("%0t: victim_way mismatch, expected %0d, got %0d",
                 $time, want.victim_way, data[3:0]);
        errors++;
      end
      if (data[4] !== want.ship_in_use) begin
        $display("%0t: ship_in_use mismatch, expected %0d, got %0d",
                 $time, want.ship_in_use, data[4]);
        errors++;
      end
      if (data[14:5] !== want.selector_value) begin
        $display("%0t: selector_value mismatch, expected %0d, got %0d",
                 $time, want.selector_value, data[14:5]);
        errors++;
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic                  in_tuser   = REQ_VICTIM;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;

  replacement_mirror mirror = new();
  int unsigned       cycle_count = 0;
  bit                idle_on = 1'b1;
  bit                long_hold_req = 1'b0;

  // Sets that random traffic keeps returning to: sample sets of both kinds and followers.
  logic [SET_IDX_W-1:0] set_pool [10] = '{0, 1, 2047, 2016, 1985, 5, 700, 1234, 33, 96};
  logic [SIG_W-1:0]     sig_pool [6]  = '{0, 12'hFFF, 7, 12'h155, 12'hAAA, 12'h3C1};

  dueling_ship_srrip_replacement i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) mirror.apply_request(in_tuser, in_tdata);
    if (rst_n && out_tvalid && out_tready) mirror.compare_reply(out_tdata);
  end

  // Result side: random stalls, plus one long hold-off on request.
  initial begin
    forever begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_tready <= 1'b0;
        repeat (300) @(posedge clk);
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  task automatic send_req(input logic req, input logic [SET_IDX_W-1:0] set_i,
                          input logic [WAY_IDX_W-1:0] way_i, input logic [PC_W-1:0] pc,
                          input logic hit);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= req;
    in_tdata  <= {hit, pc, way_i, set_i};
    do @(posedge clk); while (!in_tready);
  endtask

  // bias 1 steers traffic to SRRIP sample sets, bias 2 to SHiP sample sets.
  task automatic random_req(input int bias);
    logic [SET_IDX_W-1:0] set_i;
    logic [WAY_IDX_W-1:0] way_i;
    logic [PC_W-1:0]      pc;
    logic                 req, hit;
    int unsigned          pick;
    pc    = {$urandom, $urandom};
    way_i = $urandom_range(0, DEF_NUM_WAYS - 1);
    if ($urandom_range(0, 1)) pc[SIG_LSB +: SIG_W] = sig_pool[$urandom_range(0, 5)];
    pick = $urandom_range(0, 99);
    if ($urandom_range(0, 9) == 0) begin
      set_i = $urandom;
      req   = $urandom_range(0, 1);
      hit   = $urandom_range(0, 1);
    end else begin
      set_i = set_pool[$urandom_range(0, 9)];
      if (bias != 0 && $urandom_range(0, 1)) begin
        if (bias == 1) set_i = $urandom_range(0, 1) ? 11'd0 : 11'd2016;
        else           set_i = $urandom_range(0, 1) ? 11'd1 : 11'd1985;
        pick = $urandom_range(40, 99);
      end
      req = (pick < 30) ? REQ_VICTIM : REQ_UPDATE;
      hit = (pick >= 55);
    end
    send_req(req, set_i, way_i, pc, hit);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed requests.
    send_req(REQ_VICTIM, 0, 0, '0, 1'b0);
    send_req(REQ_VICTIM, 2047, 15, '1, 1'b1);
    send_req(REQ_UPDATE, 2047, 15, '1, 1'b0);
    send_req(REQ_UPDATE, 2047, 15, '0, 1'b1);
    // Same signature again, now trained above the start value: inserts at zero.
    send_req(REQ_UPDATE, 2047, 3, 64'h3FFC, 1'b0);
    send_req(REQ_UPDATE, 1, 0, '0, 1'b0);
    send_req(REQ_UPDATE, 1, 0, 64'h14, 1'b0);
    // Refilling a line that never got reused drains its counter to zero.
    repeat (4) send_req(REQ_UPDATE, 1, 1, 64'hF000_0000_0000_001C, 1'b0);
    send_req(REQ_UPDATE, 0, 0, 64'h1234_5678_9ABC_DEF0, 1'b1);
    send_req(REQ_UPDATE, 1, 1, '1, 1'b1);
    send_req(REQ_VICTIM, 1, 0, '0, 1'b0);
    send_req(REQ_UPDATE, 2016, 7, 64'h8000_0000_0000_0000, 1'b0);
    send_req(REQ_VICTIM, 2016, 0, '0, 1'b0);
    send_req(REQ_UPDATE, 33, 0, 64'h5555_5555_5555_5555, 1'b1);
    send_req(REQ_UPDATE, 700, 9, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
    send_req(REQ_VICTIM, 700, 15, '1, 1'b1);

    repeat (200) random_req(0);
    repeat (300) random_req(1);

    // Let the block drain completely before going on.
    in_tvalid <= 1'b0;
    while (mirror.awaited_replies.size() != 0) @(posedge clk);

    long_hold_req = 1'b1;
    repeat (300) random_req(2);

    idle_on = 1'b0;
    repeat (150) random_req(0);
    in_tvalid <= 1'b0;

    while (mirror.awaited_replies.size() != 0) @(posedge clk);
    repeat (2 * DEF_NUM_WAYS + 10) @(posedge clk);
    if (mirror.errors == 0 && mirror.awaited_replies.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
